[rtl/gbb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gbb_pkg;

   // field widths
   localparam int COORD_W     = 11;
   localparam int DIM_W       = 8;
   localparam int SLANT_W     = 7;
   localparam int COLOR_W     = 8;
   localparam int BYTE_W      = 8;
   localparam int PIX_W       = 10;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 11;

   // bit walk and divider sizing
   localparam int BIT_IDX_W = $clog2(BYTE_W);
   localparam int DIV_STEPS = DIM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int SUM_W     = COORD_W + 2;

   // largest clip bound the screen registers can give
   localparam logic [CSR_DATA_W-1:0] CLIP_LIMIT = 11'd1024;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 1'd1;

   // reset values of the screen registers
   localparam logic [CSR_DATA_W-1:0] SCREEN_WIDTH_RST  = 11'd280;
   localparam logic [CSR_DATA_W-1:0] SCREEN_HEIGHT_RST = 11'd240;

   typedef enum logic {
      CMD_START,
      CMD_BYTE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type               kind;
      logic signed [COORD_W-1:0]  glyph_x;
      logic signed [COORD_W-1:0]  glyph_y;
      logic [DIM_W-1:0]           width;
      logic [DIM_W-1:0]           height;
      logic [SLANT_W-1:0]         slant;
      logic [COLOR_W-1:0]         color;
      logic [BYTE_W-1:0]          data;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] width;
      logic [CSR_DATA_W-1:0] height;
   } screen_cfg_type;

   typedef struct packed {
      logic               start;
      logic [DIM_W-1:0]   dividend;
      logic [SLANT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIM_W-1:0]   quotient;
      logic [SLANT_W-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic [PIX_W-1:0]   x;
      logic [PIX_W-1:0]   y;
      logic [COLOR_W-1:0] color;
   } pixel_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_BITS,
      BK_FLUSH
   } back_state_type;

   typedef struct packed {
      back_state_type   state;
      logic             pend_valid;
      logic [DIM_W-1:0] row;
      logic [DIM_W-1:0] height;
   } back_status_type;

endpackage

`default_nettype wire

[rtl/gbb_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// glyph command channel
interface gbb_req_if;
   logic                               valid;
   logic                               ready;
   logic                               mode;
   logic signed [gbb_pkg::COORD_W-1:0] glyph_x;
   logic signed [gbb_pkg::COORD_W-1:0] glyph_y;
   logic [gbb_pkg::DIM_W-1:0]          glyph_width;
   logic [gbb_pkg::DIM_W-1:0]          glyph_height;
   logic [gbb_pkg::SLANT_W-1:0]        slant_divisor;
   logic [gbb_pkg::COLOR_W-1:0]        ink_color;
   logic [gbb_pkg::BYTE_W-1:0]         data_byte;

   modport source (
      output valid, mode, glyph_x, glyph_y, glyph_width, glyph_height,
             slant_divisor, ink_color, data_byte,
      input  ready
   );
   modport sink (
      input  valid, mode, glyph_x, glyph_y, glyph_width, glyph_height,
             slant_divisor, ink_color, data_byte,
      output ready
   );
endinterface

// pixel write channel
interface gbb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gbb_pkg::PIX_W-1:0]   pixel_x;
   logic [gbb_pkg::PIX_W-1:0]   pixel_y;
   logic [gbb_pkg::COLOR_W-1:0] pixel_color;
   logic                        last;

   modport source (
      output valid, pixel_x, pixel_y, pixel_color, last,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, pixel_color, last,
      output ready
   );
endinterface

`default_nettype wire

[rtl/gbb_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module gbb_front (
   input  logic               clock,
   input  logic               reset,
   gbb_req_if.sink            req_if,
   input  gbb_pkg::qstat_type q_stat,
   output logic               q_push,
   output gbb_pkg::cmd_type   q_data
);
   import gbb_pkg::*;

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_ff, hold_in;
   cmd_type decoded;
   logic    accept;

   // classify the incoming transaction
   always_comb begin
      decoded.kind    = req_if.mode ? CMD_BYTE : CMD_START;
      decoded.glyph_x = req_if.glyph_x;
      decoded.glyph_y = req_if.glyph_y;
      decoded.width   = req_if.glyph_width;
      decoded.height  = req_if.glyph_height;
      decoded.slant   = req_if.slant_divisor;
      decoded.color   = req_if.ink_color;
      decoded.data    = req_if.data_byte;
   end

   // holding stage in front of the queue
   assign req_if.ready = !hold_valid_ff || !q_stat.full;
   assign accept       = req_if.valid && req_if.ready;
   assign q_push       = hold_valid_ff && !q_stat.full;
   assign q_data       = hold_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_in       = decoded;
      end else if (q_push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

endmodule

`default_nettype wire

[rtl/gbb_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module gbb_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gbb_pkg::cmd_type    push_data,
   input  logic                pop,
   output gbb_pkg::cmd_type    pop_data,
   output gbb_pkg::qstat_type  stat
);
   import gbb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_data   = slot_ff[rd_ptr_ff];

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/gbb_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module gbb_div (
   input  logic                 clock,
   input  logic                 reset,
   input  gbb_pkg::div_req_type div_req,
   output gbb_pkg::div_rsp_type div_rsp
);
   import gbb_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIM_W-1:0]     dvd_ff, dvd_in;
   logic [SLANT_W-1:0]   rem_ff, rem_in;
   logic [SLANT_W-1:0]   dsr_ff, dsr_in;
   logic [SLANT_W:0]     trial;
   logic [SLANT_W:0]     diff;
   logic                 ge;

   // one restoring step per cycle, quotient bits shift in behind the dividend
   always_comb begin
      trial = {rem_ff, dvd_ff[DIM_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      ge    = (trial >= {1'b0, dsr_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIM_W-2:0], ge};
         rem_in = ge ? diff[SLANT_W-1:0] : trial[SLANT_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = dvd_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

[rtl/gbb_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module gbb_back (
   input  logic                     clock,
   input  logic                     reset,
   input  gbb_pkg::screen_cfg_type  cfg,
   input  gbb_pkg::cmd_type         q_head,
   input  gbb_pkg::qstat_type       q_stat,
   output logic                     q_pop,
   output gbb_pkg::div_req_type     div_req,
   input  gbb_pkg::div_rsp_type     div_rsp,
   gbb_rsp_if.source                rsp_if,
   output gbb_pkg::back_status_type status
);
   import gbb_pkg::*;

   back_state_type state_ff, state_in;

   // glyph context
   logic signed [COORD_W-1:0] origin_x_ff, origin_x_in;
   logic signed [COORD_W-1:0] origin_y_ff, origin_y_in;
   logic [DIM_W-1:0]          width_ff, width_in;
   logic [DIM_W-1:0]          height_ff, height_in;
   logic [SLANT_W-1:0]        slant_ff, slant_in;
   logic [COLOR_W-1:0]        color_ff, color_in;
   logic [DIM_W-1:0]          row_ff, row_in;
   logic [DIM_W-1:0]          col_ff, col_in;

   // slant shift kept as quotient and remainder of (height - row) / slant
   logic [DIM_W-1:0]          shift_ff, shift_in;
   logic [SLANT_W-1:0]        rem_ff, rem_in;

   // byte walk
   logic [BYTE_W-1:0]         byte_ff, byte_in;
   logic [BIT_IDX_W-1:0]      k_ff, k_in;

   // pixel held until it is known whether another one follows in the byte
   logic                      pend_valid_ff, pend_valid_in;
   pixel_type                 pend_ff, pend_in;

   // output register
   logic                      out_valid_ff, out_valid_in;
   pixel_type                 out_pix_ff, out_pix_in;
   logic                      out_last_ff, out_last_in;

   logic [CSR_DATA_W-1:0]     xmax, ymax;
   logic [SUM_W-1:0]          sum_x, sum_y;
   logic                      visible;
   logic                      hit;
   logic                      can_push;
   logic                      push;
   pixel_type                 push_pix;
   logic                      push_last;
   pixel_type                 cur_pix;

   // clip bounds and screen position of the current bit
   always_comb begin
      xmax  = (cfg.width > CLIP_LIMIT) ? CLIP_LIMIT : cfg.width;
      ymax  = (cfg.height > CLIP_LIMIT) ? CLIP_LIMIT : cfg.height;
      sum_x = {{2{origin_x_ff[COORD_W-1]}}, origin_x_ff}
            + {{(SUM_W - DIM_W){1'b0}}, shift_ff}
            + {{(SUM_W - DIM_W){1'b0}}, col_ff};
      sum_y = {{2{origin_y_ff[COORD_W-1]}}, origin_y_ff}
            + {{(SUM_W - DIM_W){1'b0}}, row_ff};
      visible = !sum_x[SUM_W-1] && (sum_x < {2'b00, xmax})
             && !sum_y[SUM_W-1] && (sum_y < {2'b00, ymax});
      hit           = byte_ff[k_ff] && visible;
      cur_pix.x     = sum_x[PIX_W-1:0];
      cur_pix.y     = sum_y[PIX_W-1:0];
      cur_pix.color = color_ff;
   end

   assign can_push = !out_valid_ff || rsp_if.ready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      origin_x_in   = origin_x_ff;
      origin_y_in   = origin_y_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      slant_in      = slant_ff;
      color_in      = color_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      shift_in      = shift_ff;
      rem_in        = rem_ff;
      byte_in       = byte_ff;
      k_in          = k_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      q_pop         = 1'b0;
      push          = 1'b0;
      push_pix      = pend_ff;
      push_last     = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = q_head.height;
      div_req.divisor  = q_head.slant;

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               q_pop = 1'b1;
               unique case (q_head.kind)
                  CMD_START: begin
                     origin_x_in = q_head.glyph_x;
                     origin_y_in = q_head.glyph_y;
                     width_in    = q_head.width;
                     height_in   = q_head.height;
                     slant_in    = q_head.slant;
                     color_in    = q_head.color;
                     row_in      = '0;
                     col_in      = '0;
                     shift_in    = '0;
                     rem_in      = '0;
                     if (q_head.slant != '0) begin
                        div_req.start = 1'b1;
                        state_in      = BK_DIVIDE;
                     end
                  end
                  CMD_BYTE: begin
                     // empty glyph: the byte is dropped without touching state
                     if (width_ff != '0 && height_ff != '0) begin
                        byte_in  = q_head.data;
                        k_in     = '0;
                        state_in = BK_BITS;
                     end
                  end
                  default: ;
               endcase
            end
         end

         BK_DIVIDE: begin
            if (div_rsp.done) begin
               shift_in = div_rsp.quotient;
               rem_in   = div_rsp.remainder;
               state_in = BK_IDLE;
            end
         end

         BK_BITS: begin
            if (row_ff >= height_ff) begin
               // past the glyph: rest of the byte is ignored
               state_in = BK_FLUSH;
            end else if (!(hit && pend_valid_ff && !can_push)) begin
               if (hit) begin
                  if (pend_valid_ff) begin
                     push     = 1'b1;
                     push_pix = pend_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = cur_pix;
               end
               // advance bit position, stepping the shift down at row ends
               if (col_ff == width_ff - 1'b1) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
                  if (slant_ff != '0) begin
                     if (rem_ff == '0) begin
                        shift_in = shift_ff - 1'b1;
                        rem_in   = slant_ff - 1'b1;
                     end else begin
                        rem_in = rem_ff - 1'b1;
                     end
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
               if (k_ff == BIT_IDX_W'(BYTE_W - 1)) begin
                  state_in = BK_FLUSH;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end

         BK_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = BK_IDLE;
            end else if (can_push) begin
               push          = 1'b1;
               push_pix      = pend_ff;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = BK_IDLE;
            end
         end

         default: state_in = BK_IDLE;
      endcase
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_pix_in   = out_pix_ff;
      out_last_in  = out_last_ff;
      if (push) begin
         out_valid_in = 1'b1;
         out_pix_in   = push_pix;
         out_last_in  = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         width_ff      <= '0;
         height_ff     <= '0;
         slant_ff      <= '0;
         color_ff      <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         shift_ff      <= '0;
         rem_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         origin_x_ff   <= origin_x_in;
         origin_y_ff   <= origin_y_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         slant_ff      <= slant_in;
         color_ff      <= color_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         shift_ff      <= shift_in;
         rem_ff        <= rem_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      byte_ff     <= byte_in;
      k_ff        <= k_in;
      pend_ff     <= pend_in;
      out_pix_ff  <= out_pix_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.pixel_x     = out_pix_ff.x;
   assign rsp_if.pixel_y     = out_pix_ff.y;
   assign rsp_if.pixel_color = out_pix_ff.color;
   assign rsp_if.last        = out_last_ff;

   assign status.state      = state_ff;
   assign status.pend_valid = pend_valid_ff;
   assign status.row        = row_ff;
   assign status.height     = height_ff;

endmodule

`default_nettype wire

[rtl/glyph_bitmap_blitter.sv]
`timescale 1ns / 1ps
`default_nettype none

// Glyph bitmap blitter: a start transaction (mode 0) latches origin, size, slant
// divisor and ink color; each following byte transaction (mode 1) is walked
// least significant bit first, one bit per cycle unless the output stalls, and
// every set bit that lands inside the screen leaves as one pixel write, the
// final write of a byte marked with last. A byte transaction is taken from the
// queue, walked bit by bit (ending early once the glyph height is used up), and
// then its held final pixel is released; an output stall holds the walk and the
// release. With a slant, a start transaction waits on the eight-step serial
// divider that finds the initial italic shift. The front stage and a QUEUE_DEPTH
// entry command queue keep accepting transactions while the back end works.
// Screen size registers are to be written through the csr port only while the
// block is idle; the block itself does not enforce this.
module glyph_bitmap_blitter #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                               clock,
   input  logic                               reset,
   gbb_req_if.sink                            req_if,
   gbb_rsp_if.source                          rsp_if,
   input  logic                               csr_we,
   input  logic [gbb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gbb_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import gbb_pkg::*;

   logic [CSR_DATA_W-1:0] screen_width_ff, screen_width_in;
   logic [CSR_DATA_W-1:0] screen_height_ff, screen_height_in;
   screen_cfg_type        cfg;
   logic                  q_push;
   logic                  q_pop;
   cmd_type               q_in_data;
   cmd_type               q_head;
   qstat_type             q_stat;
   div_req_type           div_req;
   div_rsp_type           div_rsp;
   back_status_type       status;

   // screen size registers
   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_we && csr_index == CSR_SCREEN_WIDTH) begin
         screen_width_in = csr_wdata;
      end
      if (csr_we && csr_index == CSR_SCREEN_HEIGHT) begin
         screen_height_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RST;
         screen_height_ff <= SCREEN_HEIGHT_RST;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
      end
   end

   assign cfg.width  = screen_width_ff;
   assign cfg.height = screen_height_ff;

   gbb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_stat (q_stat),
      .q_push (q_push),
      .q_data (q_in_data)
   );

   gbb_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .pop_data  (q_head),
      .stat      (q_stat)
   );

   gbb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   gbb_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_head  (q_head),
      .q_stat  (q_stat),
      .q_pop   (q_pop),
      .div_req (div_req),
      .div_rsp (div_rsp),
      .rsp_if  (rsp_if),
      .status  (status)
   );

   // bit walk never runs past the glyph height
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      status.row <= status.height)
      else $error("bit row beyond glyph height");

   // a held pixel is always released before the next command is taken
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (status.state == BK_IDLE) |-> !status.pend_valid)
      else $error("pixel still held while idle");

   // queue flags are consistent
   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue full and empty at once");

   // nothing is popped from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

[sim/gbb_pixel_checker.sv]
`timescale 1ns / 1ps

// watches the glyph and pixel channels, predicts every pixel write and
// compares each accepted write with the oldest one still owed
module gbb_pixel_checker (
   input  logic                            clock,
   input  logic                            reset,
   gbb_req_if                              req_if,
   gbb_rsp_if                              rsp_if,
   input  logic                            csr_we,
   input  logic [gbb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gbb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              pending
);
   import gbb_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0]   x;
      logic [PIX_W-1:0]   y;
      logic [COLOR_W-1:0] color;
      logic               last;
   } pixel_write_type;

   pixel_write_type owed_pixels[$];
   pixel_write_type oldest_pixel;
   cmd_type         seen_cmd;

   // screen size and latched glyph
   logic [CSR_DATA_W-1:0]     screen_cols;
   logic [CSR_DATA_W-1:0]     screen_rows;
   logic signed [COORD_W-1:0] glyph_left;
   logic signed [COORD_W-1:0] glyph_top;
   logic [DIM_W-1:0]          glyph_cols;
   logic [DIM_W-1:0]          glyph_rows;
   logic [SLANT_W-1:0]        glyph_slant;
   logic [COLOR_W-1:0]        glyph_ink;
   logic [DIM_W-1:0]          walk_row;
   logic [DIM_W-1:0]          walk_col;

   function automatic int clip_bound(input logic [CSR_DATA_W-1:0] screen_reg);
      return (screen_reg > CLIP_LIMIT) ? int'(CLIP_LIMIT) : int'(screen_reg);
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns pixel check: %s", $time, what);
      fail_count++;
   endtask

   // latch a glyph header, or walk one bitmap byte into owed pixel writes
   task automatic blit_command(input cmd_type cmd);
      int              x_limit;
      int              y_limit;
      int              shift;
      int              px;
      int              py;
      int              owed_before;
      pixel_write_type pix;
      if (cmd.kind == CMD_START) begin
         glyph_left  = cmd.glyph_x;
         glyph_top   = cmd.glyph_y;
         glyph_cols  = cmd.width;
         glyph_rows  = cmd.height;
         glyph_slant = cmd.slant;
         glyph_ink   = cmd.color;
         walk_row    = '0;
         walk_col    = '0;
      end else if (glyph_cols != 0 && glyph_rows != 0) begin
         x_limit     = clip_bound(screen_cols);
         y_limit     = clip_bound(screen_rows);
         owed_before = owed_pixels.size();
         for (int k = 0; k < BYTE_W; k++) begin
            // bits past the glyph are dropped and the walk stays put
            if (walk_row >= glyph_rows) break;
            if (cmd.data[k]) begin
               shift = 0;
               if (glyph_slant != 0)
                  shift = (int'(glyph_rows) - int'(walk_row)) / int'(glyph_slant);
               px = int'(glyph_left) + shift + int'(walk_col);
               py = int'(glyph_top) + int'(walk_row);
               if (px >= 0 && px < x_limit && py >= 0 && py < y_limit) begin
                  pix.x     = px[PIX_W-1:0];
                  pix.y     = py[PIX_W-1:0];
                  pix.color = glyph_ink;
                  pix.last  = 1'b0;
                  owed_pixels.push_back(pix);
               end
            end
            walk_col++;
            if (walk_col >= glyph_cols) begin
               walk_col = '0;
               walk_row++;
            end
         end
         if (owed_pixels.size() > owed_before)
            owed_pixels[owed_pixels.size()-1].last = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         screen_cols = SCREEN_WIDTH_RST;
         screen_rows = SCREEN_HEIGHT_RST;
         glyph_left  = '0;
         glyph_top   = '0;
         glyph_cols  = '0;
         glyph_rows  = '0;
         glyph_slant = '0;
         glyph_ink   = '0;
         walk_row    = '0;
         walk_col    = '0;
         owed_pixels.delete();
      end else begin
         // pixel write transaction against the oldest owed write
         if (rsp_if.valid && rsp_if.ready) begin
            if (owed_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected pixel x %0d y %0d color %0d",
                  rsp_if.pixel_x, rsp_if.pixel_y, rsp_if.pixel_color));
            end else begin
               oldest_pixel = owed_pixels.pop_front();
               if (rsp_if.pixel_x !== oldest_pixel.x)
                  report_mismatch($sformatf("pixel_x got %0d want %0d",
                     rsp_if.pixel_x, oldest_pixel.x));
               if (rsp_if.pixel_y !== oldest_pixel.y)
                  report_mismatch($sformatf("pixel_y got %0d want %0d",
                     rsp_if.pixel_y, oldest_pixel.y));
               if (rsp_if.pixel_color !== oldest_pixel.color)
                  report_mismatch($sformatf("pixel_color got %0d want %0d",
                     rsp_if.pixel_color, oldest_pixel.color));
               if (rsp_if.last !== oldest_pixel.last)
                  report_mismatch($sformatf("last got %b want %b",
                     rsp_if.last, oldest_pixel.last));
            end
         end
         // screen size writes
         if (csr_we) begin
            if (csr_index == CSR_SCREEN_WIDTH)
               screen_cols = csr_wdata;
            else if (csr_index == CSR_SCREEN_HEIGHT)
               screen_rows = csr_wdata;
         end
         // glyph transaction
         if (req_if.valid && req_if.ready) begin
            seen_cmd.kind    = cmd_kind_type'(req_if.mode);
            seen_cmd.glyph_x = req_if.glyph_x;
            seen_cmd.glyph_y = req_if.glyph_y;
            seen_cmd.width   = req_if.glyph_width;
            seen_cmd.height  = req_if.glyph_height;
            seen_cmd.slant   = req_if.slant_divisor;
            seen_cmd.color   = req_if.ink_color;
            seen_cmd.data    = req_if.data_byte;
            blit_command(seen_cmd);
         end
      end
      pending = owed_pixels.size();
   end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
   import gbb_pkg::*;

   localparam int CLK_HALF        = 4;
   localparam int RESET_CYCLES    = 3;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int RSP_HOLD_CYCLES = 250;
   localparam int SETTLE_CYCLES   = 64;
   localparam int MAX_RUN_BYTES   = 24;
   localparam int PHASES          = 7;

   // screen size, idling, sink stall percentage and item budget of each random phase
   localparam int PHASE_COLS  [PHASES] = '{1024, 2047, 640, 300, 1, 0, 2047};
   localparam int PHASE_ROWS  [PHASES] = '{1024, 2047, 480, 200, 1, 2047, 0};
   localparam int PHASE_IDLE  [PHASES] = '{0, 48, 0, 29, 29, 0, 48};
   localparam int PHASE_STALL [PHASES] = '{0, 0, 48, 29, 29, 48, 0};
   localparam int PHASE_ITEMS [PHASES] = '{45, 45, 45, 45, 8, 6, 6};

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic hold_toggle   = 1'b0;
   logic hold_seen;
   int   screen_cols   = 280;
   int   screen_rows   = 240;
   int   idle_cycles   = 0;
   int   fail_count;
   int   pending;

   gbb_req_if req_if ();
   gbb_rsp_if rsp_if ();

   glyph_bitmap_blitter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   gbb_pixel_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // clock
   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // pixel sink: random stalls, or one long hold-off when requested
   initial begin
      hold_seen = 1'b0;
      forever begin
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
            @(posedge clock);
         end
      end
   end

   // every field random, then the kind forced
   function automatic cmd_type random_fields(input cmd_kind_type kind);
      cmd_type    cmd;
      logic [63:0] bits;
      bits     = {$urandom, $urandom};
      cmd      = bits[$bits(cmd_type)-1:0];
      cmd.kind = kind;
      return cmd;
   endfunction

   function automatic cmd_type make_start(input int x, input int y, input int cols,
                                          input int rows, input int slant, input int ink);
      cmd_type cmd;
      cmd         = random_fields(CMD_START);
      cmd.glyph_x = x[COORD_W-1:0];
      cmd.glyph_y = y[COORD_W-1:0];
      cmd.width   = cols[DIM_W-1:0];
      cmd.height  = rows[DIM_W-1:0];
      cmd.slant   = slant[SLANT_W-1:0];
      cmd.color   = ink[COLOR_W-1:0];
      return cmd;
   endfunction

   function automatic cmd_type make_byte(input logic [BYTE_W-1:0] bits);
      cmd_type cmd;
      cmd      = random_fields(CMD_BYTE);
      cmd.data = bits;
      return cmd;
   endfunction

   // mostly small glyphs, now and then empty or large
   function automatic int pick_dim();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5) return 0;
      if (pick < 12) return $urandom_range(64, 255);
      return $urandom_range(1, 12);
   endfunction

   // placement near the visible screen, sometimes anywhere
   function automatic int pick_coord(input int span);
      int hi;
      hi = (span + 4 > 1023) ? 1023 : span + 4;
      if ($urandom_range(99) < 15) return $urandom_range(2047) - 1024;
      return $urandom_range(hi + 20) - 20;
   endfunction

   function automatic cmd_type random_start();
      int slant;
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) slant = 0;
      else if (pick < 75) slant = $urandom_range(1, 4);
      else slant = $urandom_range(5, 127);
      return make_start(pick_coord(screen_cols), pick_coord(screen_rows), pick_dim(),
                        pick_dim(), slant, $urandom_range(255));
   endfunction

   // offer one glyph transaction, idling at random first
   task automatic send_cmd(input cmd_type cmd);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.mode          <= cmd.kind;
      req_if.glyph_x       <= cmd.glyph_x;
      req_if.glyph_y       <= cmd.glyph_y;
      req_if.glyph_width   <= cmd.width;
      req_if.glyph_height  <= cmd.height;
      req_if.slant_divisor <= cmd.slant;
      req_if.ink_color     <= cmd.color;
      req_if.data_byte     <= cmd.data;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // a start and its bitmap, sometimes after a stray command, cut short or followed by a spare byte
   task automatic send_glyph_run(output int counted);
      cmd_type cmd;
      int      needed;
      int      nbytes;
      counted = 0;
      if ($urandom_range(99) < 8) begin
         send_cmd(random_fields(cmd_kind_type'($urandom_range(1))));
         counted++;
      end
      cmd = random_start();
      send_cmd(cmd);
      needed = (int'(cmd.width) * int'(cmd.height) + 7) / 8;
      nbytes = (needed > MAX_RUN_BYTES) ? MAX_RUN_BYTES : needed;
      if ($urandom_range(99) < 15) nbytes = $urandom_range(nbytes);
      for (int i = 0; i < nbytes; i++) begin
         if ($urandom_range(99) < 15) send_cmd(make_byte(8'hFF));
         else send_cmd(random_fields(CMD_BYTE));
      end
      if ($urandom_range(99) < 15) begin
         send_cmd(random_fields(CMD_BYTE));
         counted++;
      end
      counted += 1 + nbytes;
   endtask

   // stop offering until every owed pixel is out and the block has settled
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_screen(input logic [CSR_DATA_W-1:0] cols,
                               input logic [CSR_DATA_W-1:0] rows);
      csr_we    <= 1'b1;
      csr_index <= CSR_SCREEN_WIDTH;
      csr_wdata <= cols;
      @(posedge clock);
      csr_index <= CSR_SCREEN_HEIGHT;
      csr_wdata <= rows;
      @(posedge clock);
      csr_we      <= 1'b0;
      screen_cols = (cols > 1024) ? 1024 : int'(cols);
      screen_rows = (rows > 1024) ? 1024 : int'(rows);
   endtask

   // stimulus
   initial begin
      int counted;
      int phase_count;
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= CSR_SCREEN_WIDTH;
      csr_wdata            <= '0;
      req_if.valid         <= 1'b0;
      req_if.mode          <= CMD_START;
      req_if.glyph_x       <= '0;
      req_if.glyph_y       <= '0;
      req_if.glyph_width   <= '0;
      req_if.glyph_height  <= '0;
      req_if.slant_divisor <= '0;
      req_if.ink_color     <= '0;
      req_if.data_byte     <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed glyphs on the reset screen size
      send_cmd(make_byte(8'hFF));                  // byte before any start
      send_cmd(make_start(0, 0, 8, 2, 0, 'hA5));
      send_cmd(make_byte(8'hFF));
      send_cmd(make_byte(8'h81));
      send_cmd(make_start(-3, 5, 5, 4, 2, 'h5A));  // slant from a negative column
      send_cmd(make_byte(8'hFF));
      send_cmd(make_byte(8'hFF));
      send_cmd(make_byte(8'hFF));                  // runs off the glyph's end
      send_cmd(make_byte(8'hFF));                  // wholly past the glyph
      send_cmd(make_start(10, 10, 0, 5, 3, 'h11)); // zero width
      send_cmd(make_byte(8'hFF));
      send_cmd(make_start(10, 10, 5, 0, 0, 'h22)); // zero height
      send_cmd(make_byte(8'hFF));
      send_cmd(make_start(1023, 1023, 255, 255, 127, 'hFF));
      send_cmd(make_byte(8'hFF));
      send_cmd(make_start(-1024, -1024, 255, 255, 1, 'h00));
      send_cmd(make_byte(8'hFF));
      send_cmd(make_start(270, 236, 16, 8, 0, 'hC3)); // clipped right and bottom
      send_cmd(make_byte(8'hFF));
      send_cmd(make_byte(8'hFF));
      send_cmd(make_byte(8'hFF));
      send_cmd(make_byte(8'hFF));
      send_cmd(make_start(0, 0, 1, 255, 127, 'h7E));
      send_cmd(make_byte(8'h00));
      send_cmd(make_byte(8'hFF));
      drain();

      // random phases over screen sizes and idling mixes
      for (int p = 0; p < PHASES; p++) begin
         write_screen(CSR_DATA_W'(PHASE_COLS[p]), CSR_DATA_W'(PHASE_ROWS[p]));
         send_idle_pct = PHASE_IDLE[p];
         rsp_stall_pct = PHASE_STALL[p];
         phase_count   = 0;
         while (phase_count < PHASE_ITEMS[p]) begin
            send_glyph_run(counted);
            phase_count += counted;
         end
         drain();
      end

      // long pixel hold-off while a dense glyph keeps coming
      write_screen(11'd280, 11'd240);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_toggle <= ~hold_toggle;
      send_cmd(make_start(4, 4, 8, 16, 0, 'h3C));
      for (int i = 0; i < 16; i++) send_cmd(make_byte(8'hFF));
      drain();

      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
